// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the spectral subtraction gain RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SGS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sgs: check failed");

// Next-cycle implication, disabled during reset
`define SGS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sgs: check failed");

`endif

// ===== rtl/core/sgs_pkg.sv =====
`timescale 1ns / 1ps
// Package for the spectral subtraction gain core: sizes, reset values, register codes.
// No dependencies.
package sgs_pkg;
    localparam int DATA_WIDTH   = 24;
    localparam int FFT_LEN      = 256;
    localparam int NUM_SEGMENTS = 4;

    localparam int ALPHA_W    = 16;
    localparam int LAMBDA_W   = 16;
    localparam int SEGF_W     = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int Q_W        = 15;   // quotient / fraction bits of Q1.15
    localparam int NUM_SHIFT  = 7;    // alpha Q8.8 to Q15 ratio

    localparam logic [ALPHA_W-1:0]  ALPHA_RST  = 16'd5120;
    localparam logic [LAMBDA_W-1:0] LAMBDA_RST = 16'd3277;
    localparam logic [SEGF_W-1:0]   SEGF_RST   = 10'd312;
    localparam logic [LAMBDA_W:0]   Q15_ONE    = 17'd32768;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEGF   = 2'd2;
endpackage

// ===== rtl/core/sgs_in_if.sv =====
`timescale 1ns / 1ps
// Input channel of the gain core: one FFT bin per beat.
// Depends on sgs_pkg for the default data width.
interface sgs_in_if #(
    parameter int DW = sgs_pkg::DATA_WIDTH
);
    logic                 valid;
    logic                 ready;
    logic                 frame_start;
    logic signed [DW-1:0] bin_real;
    logic signed [DW-1:0] bin_imag;

    modport source (output valid, frame_start, bin_real, bin_imag, input ready);
    modport sink   (input valid, frame_start, bin_real, bin_imag, output ready);
endinterface

// ===== rtl/core/sgs_out_if.sv =====
`timescale 1ns / 1ps
// Output channel of the gain core: scaled bin and its gain per beat.
// Depends on sgs_pkg for the default data width.
interface sgs_out_if #(
    parameter int DW = sgs_pkg::DATA_WIDTH
);
    logic                 valid;
    logic                 ready;
    logic signed [DW-1:0] out_real;
    logic signed [DW-1:0] out_imag;
    logic [15:0]          bin_gain;

    modport source (output valid, out_real, out_imag, bin_gain, input ready);
    modport sink   (input valid, out_real, out_imag, bin_gain, output ready);
endinterface

// ===== rtl/core/spectral_subtraction_gain_core.sv =====
`timescale 1ns / 1ps
// Top level of the spectral subtraction gain core (minimum statistics noise estimate).
// Depends on sgs_pkg, sgs_in_if, sgs_out_if, sgs_sqrt, sgs_min_track, sgs_div.
//
//  channel  | dir | beat contents
//  ---------+-----+--------------------------------------------------
//  i_bin    | in  | frame_start, bin_real, bin_imag (valid/ready)
//  o_res    | out | out_real, out_imag, bin_gain (valid/ready)
//  i_cfg_*  | in  | register index and data, written when i_cfg_we
//
// One bin enters per cycle while i_bin.ready is high. The square root gives one
// bit per stage, the divider has fifteen quotient stages, store RAM read/update two.
// The whole pipeline holds on a stalled output; ready is low only while the
// output register is full and not taken, or during the store clear.
// After reset the stores are cleared one bin row per cycle, with
// i_bin.ready low until the clear ends. Configuration writes are taken at any time.
`include "assert_macros.svh"

module spectral_subtraction_gain_core #(
    parameter int DATA_WIDTH   = sgs_pkg::DATA_WIDTH,
    parameter int FFT_LEN      = sgs_pkg::FFT_LEN,
    parameter int NUM_SEGMENTS = sgs_pkg::NUM_SEGMENTS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    sgs_in_if.sink                           i_bin,
    sgs_out_if.source                        o_res,
    input  logic                             i_cfg_we,
    input  logic [sgs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sgs_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import sgs_pkg::*;

    localparam int DW     = DATA_WIDTH;
    localparam int PTR_W  = $clog2(FFT_LEN);
    localparam int SEL_W  = $clog2(NUM_SEGMENTS);
    localparam int RI_W   = 2 * DW;
    localparam int SIDE_W = PTR_W + SEL_W + 1 + RI_W;
    localparam int PROD_W = ALPHA_W + DW;
    localparam int NUM_W  = PROD_W + NUM_SHIFT;
    localparam int SC_W   = DW + LAMBDA_W + 1;   // bin times Q1.15 gain

    // configuration
    logic [ALPHA_W-1:0]  r_alpha;
    logic [LAMBDA_W-1:0] r_lambda;
    logic [SEGF_W-1:0]   r_segf;

    // frame bookkeeping
    logic [SEGF_W-1:0] r_fcnt;
    logic [SEL_W-1:0]  r_newest;
    logic [PTR_W-1:0]  r_ptr;
    logic [SEGF_W-1:0] fc_inc;
    logic [SEGF_W-1:0] cur_fc;
    logic [SEL_W-1:0]  cur_sel;
    logic [PTR_W-1:0]  cur_ptr;
    logic [PTR_W-1:0]  n_ptr;

    logic en;
    logic acc;
    logic mt_busy;

    // stage A: captured bin; B: squares; C: sum of squares
    logic              rA_vld;
    logic [SIDE_W-1:0] rA_side;
    logic signed [DW-1:0] a_re;
    logic signed [DW-1:0] a_im;
    logic              rB_vld;
    logic [2*DW-1:0]   rB_sq_re;
    logic [2*DW-1:0]   rB_sq_im;
    logic [SIDE_W-1:0] rB_side;
    logic              rC_vld;
    logic [2*DW-1:0]   rC_rad;
    logic [SIDE_W-1:0] rC_side;
    logic signed [2*DW-1:0] sq_re;
    logic signed [2*DW-1:0] sq_im;

    // square root out
    logic              sq_vld;
    logic [DW-1:0]     sq_mag;
    logic [SIDE_W-1:0] sq_side;

    // store tracker out
    logic            mt_vld;
    logic [DW-1:0]   mt_mag;
    logic [DW-1:0]   mt_nmin;
    logic [RI_W-1:0] mt_side;

    // noise product
    logic              rP_vld;
    logic [PROD_W-1:0] rP_prod;
    logic [DW-1:0]     rP_mag;
    logic [RI_W-1:0]   rP_side;

    // divider out
    logic            dv_vld;
    logic [Q_W-1:0]  dv_quo;
    logic            dv_pass;
    logic [RI_W-1:0] dv_side;

    // gain stage
    logic [LAMBDA_W-1:0] lam;
    logic [LAMBDA_W:0]   cand;
    logic [LAMBDA_W-1:0] gain;
    logic                rG_vld;
    logic [LAMBDA_W-1:0] rG_gain;
    logic [RI_W-1:0]     rG_side;

    // scale stage
    logic                   rS_vld;
    logic signed [SC_W-1:0] rS_re;
    logic signed [SC_W-1:0] rS_im;
    logic [LAMBDA_W-1:0]    rS_gain;
    logic signed [DW-1:0]   g_re;
    logic signed [DW-1:0]   g_im;
    logic signed [DW-1:0]   sat_re;
    logic signed [DW-1:0]   sat_im;

    // output register
    logic                 r_out_vld;
    logic signed [DW-1:0] r_out_re;
    logic signed [DW-1:0] r_out_im;
    logic [LAMBDA_W-1:0]  r_out_gain;

    // check terms
    logic gain_ok;
    logic fs_acc;

    localparam logic signed [DW+1:0] Q_MAX = {3'b000, {(DW-1){1'b1}}};
    localparam logic signed [DW+1:0] Q_MIN = {3'b111, {(DW-1){1'b0}}};

    // ---------------------------------------------------------------
    // handshake: one global advance for every stage
    // ---------------------------------------------------------------
    assign en          = !r_out_vld || o_res.ready;
    assign i_bin.ready = en && !mt_busy;
    assign acc         = i_bin.valid && i_bin.ready;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha  <= ALPHA_RST;
            r_lambda <= LAMBDA_RST;
            r_segf   <= SEGF_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ALPHA:  r_alpha  <= i_cfg_data[ALPHA_W-1:0];
                CFG_LAMBDA: r_lambda <= i_cfg_data[LAMBDA_W-1:0];
                CFG_SEGF:   r_segf   <= i_cfg_data[SEGF_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // frame counter, store rotation and bin pointer
    // ---------------------------------------------------------------
    assign fc_inc = r_fcnt + 1'b1;

    always_comb begin
        cur_fc  = r_fcnt;
        cur_sel = r_newest;
        cur_ptr = r_ptr;
        if (i_bin.frame_start) begin
            cur_ptr = '0;
            if (fc_inc >= r_segf) begin
                cur_fc  = '0;
                cur_sel = (r_newest == SEL_W'(NUM_SEGMENTS - 1)) ? '0 : r_newest + 1'b1;
            end else begin
                cur_fc = fc_inc;
            end
        end
        n_ptr = (cur_ptr == PTR_W'(FFT_LEN - 1)) ? '0 : cur_ptr + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fcnt   <= '0;
            r_newest <= '0;
            r_ptr    <= '0;
        end else if (acc) begin
            r_fcnt   <= cur_fc;
            r_newest <= cur_sel;
            r_ptr    <= n_ptr;
        end
    end

    // ---------------------------------------------------------------
    // front stages: capture, square, sum
    // ---------------------------------------------------------------
    assign a_re  = rA_side[RI_W-1:DW];
    assign a_im  = rA_side[DW-1:0];
    assign sq_re = a_re * a_re;
    assign sq_im = a_im * a_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rA_vld <= 1'b0;
            rB_vld <= 1'b0;
            rC_vld <= 1'b0;
        end else if (en) begin
            rA_vld <= i_bin.valid && !mt_busy;
            rB_vld <= rA_vld;
            rC_vld <= rB_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rA_side  <= {cur_ptr, cur_sel, (cur_fc == '0), i_bin.bin_real, i_bin.bin_imag};
            rB_sq_re <= sq_re;
            rB_sq_im <= sq_im;
            rB_side  <= rA_side;
            rC_rad   <= rB_sq_re + rB_sq_im;
            rC_side  <= rB_side;
        end
    end

    // magnitude; the root of two full-scale squares stays below 2^DW,
    // so the saturation limit is never reached
    sgs_sqrt #(
        .DW (DW),
        .SW (SIDE_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (rC_vld),
        .i_rad   (rC_rad),
        .i_side  (rC_side),
        .o_valid (sq_vld),
        .o_root  (sq_mag),
        .o_side  (sq_side)
    );

    sgs_min_track #(
        .DW      (DW),
        .FFT_LEN (FFT_LEN),
        .NS      (NUM_SEGMENTS),
        .SW      (RI_W)
    ) u_min (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_vld),
        .i_mag   (sq_mag),
        .i_ptr   (sq_side[SIDE_W-1 -: PTR_W]),
        .i_sel   (sq_side[RI_W+SEL_W:RI_W+1]),
        .i_seed  (sq_side[RI_W]),
        .i_side  (sq_side[RI_W-1:0]),
        .o_busy  (mt_busy),
        .o_valid (mt_vld),
        .o_mag   (mt_mag),
        .o_nmin  (mt_nmin),
        .o_side  (mt_side)
    );

    // ---------------------------------------------------------------
    // noise = alpha * minimum; ratio = noise * 128 / magnitude
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rP_vld <= 1'b0;
        end else if (en) begin
            rP_vld <= mt_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rP_prod <= r_alpha * mt_nmin;
            rP_mag  <= mt_mag;
            rP_side <= mt_side;
        end
    end

    sgs_div #(
        .DW (DW),
        .SW (RI_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (rP_vld),
        .i_num   ({rP_prod, {NUM_SHIFT{1'b0}}}),
        .i_den   (rP_mag),
        .i_side  (rP_side),
        .o_valid (dv_vld),
        .o_quo   (dv_quo),
        .o_pass  (dv_pass),
        .o_side  (dv_side)
    );

    // ---------------------------------------------------------------
    // gain = max(lambda, 1 - ratio); zero magnitude or ratio >= 1 gives lambda
    // ---------------------------------------------------------------
    assign lam  = ({1'b0, r_lambda} > Q15_ONE) ? Q15_ONE[LAMBDA_W-1:0] : r_lambda;
    assign cand = Q15_ONE - {{(LAMBDA_W+1-Q_W){1'b0}}, dv_quo};
    assign gain = (dv_pass && (cand > {1'b0, lam})) ? cand[LAMBDA_W-1:0] : lam;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rG_vld <= 1'b0;
            rS_vld <= 1'b0;
        end else if (en) begin
            rG_vld <= dv_vld;
            rS_vld <= rG_vld;
        end
    end

    assign g_re = rG_side[RI_W-1:DW];
    assign g_im = rG_side[DW-1:0];

    always_ff @(posedge i_clk) begin
        if (en) begin
            rG_gain <= gain;
            rG_side <= dv_side;
            rS_re   <= g_re * $signed({1'b0, rG_gain});
            rS_im   <= g_im * $signed({1'b0, rG_gain});
            rS_gain <= rG_gain;
        end
    end

    // round half up, floor shift, clamp to the data range
    always_comb begin
        logic signed [SC_W-1:0] v_re;
        logic signed [SC_W-1:0] v_im;
        logic signed [DW+1:0]   q_re;
        logic signed [DW+1:0]   q_im;
        v_re = rS_re + SC_W'(16384);
        v_im = rS_im + SC_W'(16384);
        q_re = v_re[SC_W-1:Q_W];
        q_im = v_im[SC_W-1:Q_W];
        if (q_re > Q_MAX) begin
            q_re = Q_MAX;
        end else if (q_re < Q_MIN) begin
            q_re = Q_MIN;
        end
        if (q_im > Q_MAX) begin
            q_im = Q_MAX;
        end else if (q_im < Q_MIN) begin
            q_im = Q_MIN;
        end
        sat_re = q_re[DW-1:0];
        sat_im = q_im[DW-1:0];
    end

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= rS_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_re   <= sat_re;
            r_out_im   <= sat_im;
            r_out_gain <= rS_gain;
        end
    end

    assign o_res.valid    = r_out_vld;
    assign o_res.out_real = r_out_re;
    assign o_res.out_imag = r_out_im;
    assign o_res.bin_gain = r_out_gain;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    assign gain_ok = (o_res.bin_gain >= lam) && ({1'b0, o_res.bin_gain} <= Q15_ONE);
    assign fs_acc  = acc && i_bin.frame_start;

    `SGS_ASSERT_IMP(a_gain_range, i_clk, i_rst_n, o_res.valid, gain_ok)
    `SGS_ASSERT_NXT(a_ptr_restart, i_clk, i_rst_n, fs_acc, r_ptr == PTR_W'(1))
    `SGS_ASSERT_NXT(a_rotate_on_frame, i_clk, i_rst_n, !fs_acc, r_newest == $past(r_newest))
endmodule

// ===== rtl/core/sgs_sqrt.sv =====
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage, sideband carried along.
// Depends on sgs_pkg.
module sgs_sqrt #(
    parameter int DW = sgs_pkg::DATA_WIDTH,
    parameter int SW = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [2*DW-1:0] i_rad,
    input  logic [SW-1:0]   i_side,
    output logic            o_valid,
    output logic [DW-1:0]   o_root,
    output logic [SW-1:0]   o_side
);
    import sgs_pkg::*;

    logic            r_vld  [DW];
    logic [2*DW-1:0] r_rad  [DW];
    logic [DW:0]     r_rem  [DW];
    logic [DW-1:0]   r_root [DW];
    logic [SW-1:0]   r_side [DW];

    for (genvar k = 0; k < DW; k++) begin : g_step
        logic            pv;
        logic [2*DW-1:0] prad;
        logic [DW:0]     prem;
        logic [DW-1:0]   proot;
        logic [SW-1:0]   pside;
        logic [DW+1:0]   sh;
        logic [DW+1:0]   trial;
        logic [DW+1:0]   diff;
        logic            ge;

        if (k == 0) begin : g_first
            assign pv    = i_valid;
            assign prad  = i_rad;
            assign prem  = '0;
            assign proot = '0;
            assign pside = i_side;
        end else begin : g_next
            assign pv    = r_vld[k-1];
            assign prad  = r_rad[k-1];
            assign prem  = r_rem[k-1];
            assign proot = r_root[k-1];
            assign pside = r_side[k-1];
        end

        assign sh    = {prem[DW-1:0], prad[2*DW-1 -: 2]};
        assign trial = {proot, 2'b01};
        assign diff  = sh - trial;
        assign ge    = (sh >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= pv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k]  <= {prad[2*DW-3:0], 2'b00};
                r_rem[k]  <= ge ? diff[DW:0] : sh[DW:0];
                r_root[k] <= {proot[DW-2:0], ge};
                r_side[k] <= pside;
            end
        end
    end

    assign o_valid = r_vld[DW-1];
    assign o_root  = r_root[DW-1];
    assign o_side  = r_side[DW-1];
endmodule

// ===== rtl/core/sgs_min_track.sv =====
`timescale 1ns / 1ps
// Per-bin minimum stores: one RAM per segment, read-update-write with forwarding.
// Depends on sgs_pkg; clears all stores after reset.
module sgs_min_track #(
    parameter int DW      = sgs_pkg::DATA_WIDTH,
    parameter int FFT_LEN = sgs_pkg::FFT_LEN,
    parameter int NS      = sgs_pkg::NUM_SEGMENTS,
    parameter int SW      = 8,
    localparam int PTR_W  = $clog2(FFT_LEN),
    localparam int SEL_W  = $clog2(NS)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [DW-1:0]    i_mag,
    input  logic [PTR_W-1:0] i_ptr,
    input  logic [SEL_W-1:0] i_sel,
    input  logic             i_seed,
    input  logic [SW-1:0]    i_side,
    output logic             o_busy,
    output logic             o_valid,
    output logic [DW-1:0]    o_mag,
    output logic [DW-1:0]    o_nmin,
    output logic [SW-1:0]    o_side
);
    import sgs_pkg::*;

    logic             r_clr_busy;
    logic [PTR_W-1:0] r_clr_addr;

    // read stage
    logic             r2_vld;
    logic [DW-1:0]    r2_mag;
    logic [PTR_W-1:0] r2_ptr;
    logic [SEL_W-1:0] r2_sel;
    logic             r2_seed;
    logic [SW-1:0]    r2_side;

    // update stage (also forwarding source)
    logic             r3_vld;
    logic [DW-1:0]    r3_mag;
    logic [DW-1:0]    r3_nmin;
    logic [PTR_W-1:0] r3_ptr;
    logic [SEL_W-1:0] r3_sel;
    logic [DW-1:0]    r3_wval;
    logic [SW-1:0]    r3_side;

    logic [DW-1:0] rd [NS];
    logic [DW-1:0] wval;
    logic [DW-1:0] nmin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == PTR_W'(FFT_LEN - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    for (genvar s = 0; s < NS; s++) begin : g_store
        logic [DW-1:0] mem [FFT_LEN];
        logic [DW-1:0] r_q;

        always_ff @(posedge i_clk) begin
            if (r_clr_busy) begin
                mem[r_clr_addr] <= '0;
            end else if (i_en && r2_vld && (r2_sel == SEL_W'(s))) begin
                mem[r2_ptr] <= wval;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q <= mem[i_ptr];
            end
        end

        assign rd[s] = r_q;
    end

    // the item one ahead wrote at the edge this one read: take its value
    always_comb begin
        logic [DW-1:0] old_v;
        logic [DW-1:0] upd_v;
        nmin = '1;
        wval = r2_mag;
        for (int s = 0; s < NS; s++) begin
            old_v = rd[s];
            if (r3_vld && (r3_sel == SEL_W'(s)) && (r3_ptr == r2_ptr)) begin
                old_v = r3_wval;
            end
            upd_v = old_v;
            if (r2_sel == SEL_W'(s)) begin
                if (r2_seed || (old_v > r2_mag)) begin
                    upd_v = r2_mag;
                end
                wval = upd_v;
            end
            if (upd_v < nmin) begin
                nmin = upd_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r2_vld <= i_valid;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_mag  <= i_mag;
            r2_ptr  <= i_ptr;
            r2_sel  <= i_sel;
            r2_seed <= i_seed;
            r2_side <= i_side;
            r3_mag  <= r2_mag;
            r3_nmin <= nmin;
            r3_ptr  <= r2_ptr;
            r3_sel  <= r2_sel;
            r3_wval <= wval;
            r3_side <= r2_side;
        end
    end

    assign o_busy  = r_clr_busy;
    assign o_valid = r3_vld;
    assign o_mag   = r3_mag;
    assign o_nmin  = r3_nmin;
    assign o_side  = r3_side;
endmodule

// ===== rtl/core/sgs_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider for the Q15 noise ratio, one quotient bit per stage.
// Depends on sgs_pkg; flags quotients of 1.0 and above, and a zero divisor.
module sgs_div #(
    parameter int DW     = sgs_pkg::DATA_WIDTH,
    parameter int SW     = 8,
    localparam int NUM_W = sgs_pkg::ALPHA_W + DW + sgs_pkg::NUM_SHIFT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [NUM_W-1:0]       i_num,
    input  logic [DW-1:0]          i_den,
    input  logic [SW-1:0]          i_side,
    output logic                   o_valid,
    output logic [sgs_pkg::Q_W-1:0] o_quo,
    output logic                   o_pass,
    output logic [SW-1:0]          o_side
);
    import sgs_pkg::*;

    localparam int HI_W = NUM_W - Q_W;

    // front stage: range check and first partial remainder
    logic             r0_vld;
    logic             r0_pass;
    logic [DW-1:0]    r0_den;
    logic [DW-1:0]    r0_rem;
    logic [Q_W-1:0]   r0_low;
    logic [SW-1:0]    r0_side;

    logic             r_vld  [Q_W];
    logic             r_pass [Q_W];
    logic [DW-1:0]    r_den  [Q_W];
    logic [DW-1:0]    r_rem  [Q_W];
    logic [Q_W-1:0]   r_low  [Q_W];
    logic [Q_W-1:0]   r_quo  [Q_W];
    logic [SW-1:0]    r_side [Q_W];

    logic [HI_W-1:0] num_hi;
    assign num_hi = i_num[NUM_W-1:Q_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (i_en) begin
            r0_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_pass <= (i_den != '0) && (num_hi < HI_W'(i_den));
            r0_den  <= i_den;
            r0_rem  <= num_hi[DW-1:0];
            r0_low  <= i_num[Q_W-1:0];
            r0_side <= i_side;
        end
    end

    for (genvar k = 0; k < Q_W; k++) begin : g_step
        logic           pv;
        logic           ppass;
        logic [DW-1:0]  pden;
        logic [DW-1:0]  prem;
        logic [Q_W-1:0] plow;
        logic [Q_W-1:0] pquo;
        logic [SW-1:0]  pside;
        logic [DW:0]    sh;
        logic [DW:0]    diff;
        logic           ge;

        if (k == 0) begin : g_first
            assign pv    = r0_vld;
            assign ppass = r0_pass;
            assign pden  = r0_den;
            assign prem  = r0_rem;
            assign plow  = r0_low;
            assign pquo  = '0;
            assign pside = r0_side;
        end else begin : g_next
            assign pv    = r_vld[k-1];
            assign ppass = r_pass[k-1];
            assign pden  = r_den[k-1];
            assign prem  = r_rem[k-1];
            assign plow  = r_low[k-1];
            assign pquo  = r_quo[k-1];
            assign pside = r_side[k-1];
        end

        assign sh   = {prem, plow[Q_W-1]};
        assign ge   = (sh >= {1'b0, pden});
        assign diff = sh - {1'b0, pden};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= pv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pass[k] <= ppass;
                r_den[k]  <= pden;
                r_rem[k]  <= ge ? diff[DW-1:0] : sh[DW-1:0];
                r_low[k]  <= {plow[Q_W-2:0], 1'b0};
                r_quo[k]  <= {pquo[Q_W-2:0], ge};
                r_side[k] <= pside;
            end
        end
    end

    assign o_valid = r_vld[Q_W-1];
    assign o_quo   = r_quo[Q_W-1];
    assign o_pass  = r_pass[Q_W-1];
    assign o_side  = r_side[Q_W-1];
endmodule

// ===== sim/spectral_subtraction_gain_core_test.sv =====
`timescale 1ns / 1ps
// Testbench for the spectral subtraction gain core: directed table then random bins,
// each result checked against a behavioural predictor or a typed-in value. Needs sgs_pkg, sgs_in_if, sgs_out_if.
module spectral_subtraction_gain_core_test;
    import sgs_pkg::*;

    localparam int DW      = DATA_WIDTH;
    localparam int LAT     = DATA_WIDTH + 24;
    localparam int N_RAND  = 1330;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [DW-1:0] re;
        logic signed [DW-1:0] im;
        logic [15:0]          gain;
    } t_gained_bin;

    // directed row: expected gain typed in only where obvious, else predictor
    typedef struct {
        bit                   fs;
        logic signed [DW-1:0] re;
        logic signed [DW-1:0] im;
        bit                   has_exp;
        t_gained_bin          exp_bin;
    } t_bin_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = CFG_ALPHA;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    sgs_in_if  #(.DW(DW)) bin_ch ();
    sgs_out_if #(.DW(DW)) res_ch ();

    spectral_subtraction_gain_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_bin      (bin_ch.sink),
        .o_res      (res_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor state
    logic [15:0]   p_alpha, p_lambda;
    logic [9:0]    p_segf, p_frames;
    logic [1:0]    p_newest;
    logic [7:0]    p_bin;
    logic [DW-1:0] p_minstore [NUM_SEGMENTS][FFT_LEN];

    t_gained_bin expected_bins [$];
    t_gained_bin forced_bins   [$];   // typed-in expectation, or zero where none
    bit          forced_valid  [$];
    int          mismatches = 0;
    longint      cycle_count = 0;
    bit          stim_done = 1'b0;
    bit          hold_off = 1'b0;

    function automatic logic [63:0] isqrt(input logic [63:0] x);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // round half up, saturate to DW bits
    function automatic logic signed [DW-1:0] apply_gain(input longint x, input longint g);
        longint v, q, hi, lo;
        hi = (longint'(1) <<< (DW - 1)) - 1;
        lo = -(longint'(1) <<< (DW - 1));
        v = x * g + 16384;
        if (v >= 0) q = v / 32768;
        else q = -((-v + 32767) / 32768);
        if (q > hi) q = hi;
        if (q < lo) q = lo;
        return q[DW-1:0];
    endfunction

    function automatic t_gained_bin predict_gain(input bit fs, input logic signed [DW-1:0] re,
                                                 input logic signed [DW-1:0] im);
        longint sre, sim;
        logic [63:0] mag, nmin, ratio;
        logic [16:0] lam, g;
        t_gained_bin r;
        sre = longint'(re);
        sim = longint'(im);
        if (fs) begin
            p_bin = '0;
            p_frames = p_frames + 1'b1;
            if (p_frames >= p_segf) begin
                p_frames = '0;
                p_newest = p_newest + 1'b1;
            end
        end
        mag = isqrt(64'(sre * sre) + 64'(sim * sim));
        if (mag > (64'd1 << DW) - 1) mag = (64'd1 << DW) - 1;
        if (p_frames == 0 || p_minstore[p_newest][p_bin] > mag)
            p_minstore[p_newest][p_bin] = mag[DW-1:0];
        nmin = (64'd1 << DW) - 1;
        for (int s = 0; s < NUM_SEGMENTS; s++)
            if (p_minstore[s][p_bin] < nmin) nmin = 64'(p_minstore[s][p_bin]);
        lam = (p_lambda > 16'd32768) ? 17'd32768 : {1'b0, p_lambda};
        g = lam;
        if (mag != 0) begin
            ratio = (64'(p_alpha) * nmin * 128) / mag;
            if (ratio < 32768 && (17'd32768 - ratio[16:0]) > lam)
                g = 17'd32768 - ratio[16:0];
        end
        r.re = apply_gain(sre, longint'(g));
        r.im = apply_gain(sim, longint'(g));
        r.gain = g[15:0];
        p_bin = p_bin + 1'b1;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input t_gained_bin got,
                                   input t_gained_bin want);
        $display("mismatch %s at cycle %0d: got %0d/%0d g%0d want %0d/%0d g%0d", what,
                 cycle_count, got.re, got.im, got.gain, want.re, want.im, want.gain);
        mismatches++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_ALPHA:  p_alpha = val;
            CFG_LAMBDA: p_lambda = val;
            default:    p_segf = val[9:0];
        endcase
        @(posedge i_clk);
    endtask

    task automatic drain_pipeline();
        while (expected_bins.size() != 0) @(posedge i_clk);
        repeat (LAT + 4) @(posedge i_clk);
    endtask

    task automatic random_gap();
        int n;
        if ($urandom_range(3) != 0) return;
        n = ($urandom_range(15) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
        bin_ch.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // offer one beat; holds valid until taken, queues the expectation
    task automatic send_bin(input bit fs, input logic signed [DW-1:0] re,
                            input logic signed [DW-1:0] im, input bit has_exp,
                            input t_gained_bin want);
        t_gained_bin pred;
        bin_ch.valid       <= 1'b1;
        bin_ch.frame_start <= fs;
        bin_ch.bin_real    <= re;
        bin_ch.bin_imag    <= im;
        @(posedge i_clk);
        while (!bin_ch.ready) @(posedge i_clk);
        pred = predict_gain(fs, re, im);
        expected_bins.push_back(pred);
        forced_valid.push_back(has_exp);
        forced_bins.push_back(want);
    endtask

    function automatic logic signed [DW-1:0] rand_field();
        case ($urandom_range(7))
            0: return {1'b0, {(DW-1){1'b1}}};
            1: return {1'b1, {(DW-1){1'b0}}};
            2: return DW'($signed($urandom_range(64)) - 32);
            3: return DW'($signed($urandom_range(4096)) - 2048);
            default: return DW'($urandom());
        endcase
    endfunction

    // whole frames mostly with random content, occasional stray frame starts
    task automatic send_random(input int count);
        int n, fl;
        n = 0;
        fl = 0;
        while (n < count) begin
            bit fs;
            fs = (fl == 0) || ($urandom_range(60) == 0);
            if (fs) fl = $urandom_range(7) == 0 ? $urandom_range(300, 200) : $urandom_range(12, 2);
            send_bin(fs, rand_field(), rand_field(), 1'b0, '0);
            fl--;
            n++;
            random_gap();
        end
        bin_ch.valid <= 1'b0;
    endtask

    // directed rows; after reset every store is zero so noise is zero and gain is 1.0, or lambda for a zero bin
    t_bin_row directed_rows [] = '{
        '{1'b0, 24'sd0, 24'sd0, 1'b1, '{24'sd0, 24'sd0, 16'd3277}},
        '{1'b0, 24'sh7FFFFF, 24'sh7FFFFF, 1'b0, '0},
        '{1'b0, -24'sd8388608, -24'sd8388608, 1'b0, '0},
        '{1'b0, 24'sh7FFFFF, -24'sd8388608, 1'b0, '0},
        '{1'b1, 24'sd1, 24'sd0, 1'b0, '0},
        '{1'b0, -24'sd1, 24'sd0, 1'b0, '0},
        '{1'b0, 24'sd0, 24'sd1, 1'b0, '0},
        '{1'b0, 24'sd0, 24'sd0, 1'b0, '0},
        '{1'b1, 24'sd1000, 24'sd1000, 1'b0, '0},
        '{1'b0, 24'sd3, -24'sd4, 1'b0, '0},
        '{1'b1, 24'sd20, 24'sd0, 1'b0, '0},
        '{1'b1, 24'sd5000, -24'sd5000, 1'b0, '0},
        '{1'b1, 24'sd2, 24'sd1, 1'b0, '0},
        '{1'b0, 24'sh555555, -24'sh2AAAAA, 1'b0, '0},
        '{1'b1, 24'sd7, 24'sd7, 1'b0, '0}
    };

    // stimulus and configuration phases
    initial begin
        bin_ch.valid = 1'b0;
        bin_ch.frame_start = 1'b0;
        bin_ch.bin_real = '0;
        bin_ch.bin_imag = '0;
        p_alpha = ALPHA_RST;
        p_lambda = LAMBDA_RST;
        p_segf = SEGF_RST;
        p_frames = '0;
        p_newest = '0;
        p_bin = '0;
        foreach (p_minstore[s, b]) p_minstore[s][b] = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults first, then tiny segments so the stores rotate often
        foreach (directed_rows[k])
            send_bin(directed_rows[k].fs, directed_rows[k].re, directed_rows[k].im,
                     directed_rows[k].has_exp, directed_rows[k].exp_bin);
        bin_ch.valid <= 1'b0;
        drain_pipeline();
        write_reg(CFG_SEGF, 16'd1);
        write_reg(CFG_ALPHA, 16'd256);
        write_reg(CFG_LAMBDA, 16'd0);
        send_random(300);
        drain_pipeline();
        write_reg(CFG_SEGF, 16'd0);              // zero: rotate on every frame
        write_reg(CFG_ALPHA, 16'hFFFF);
        write_reg(CFG_LAMBDA, 16'd32768);
        send_random(200);
        drain_pipeline();
        write_reg(CFG_SEGF, 16'd1023);
        write_reg(CFG_ALPHA, 16'd0);
        write_reg(CFG_LAMBDA, 16'hFFFF);         // above 1.0, clamps to 1.0
        send_random(200);
        drain_pipeline();
        write_reg(CFG_SEGF, 16'd3);
        write_reg(CFG_ALPHA, 16'd32);
        write_reg(CFG_LAMBDA, 16'd1000);
        hold_off = 1'b1;
        send_random(400);
        hold_off = 1'b0;
        drain_pipeline();
        write_reg(CFG_SEGF, 16'd2);
        write_reg(CFG_ALPHA, 16'd1);
        write_reg(CFG_LAMBDA, 16'd1);
        send_random(N_RAND - 1100);
        drain_pipeline();
        stim_done = 1'b1;
    end

    // receiver: random stalls, plus one long hold-off while input keeps coming
    initial begin
        int n;
        bit stalled_long;
        stalled_long = 1'b0;
        res_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_off && !stalled_long) begin
                stalled_long = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (300) @(posedge i_clk);
            end else if ($urandom_range(3) == 0) begin
                n = ($urandom_range(15) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
                res_ch.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            repeat ($urandom_range(20, 1)) @(posedge i_clk);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_gained_bin got, want, typed;
        bit typed_ok;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got.re = res_ch.out_real;
            got.im = res_ch.out_imag;
            got.gain = res_ch.bin_gain;
            if (expected_bins.size() == 0) begin
                report_mismatch("unexpected beat", got, '0);
            end else begin
                want = expected_bins.pop_front();
                typed = forced_bins.pop_front();
                typed_ok = forced_valid.pop_front();
                if (typed_ok) want = typed;
                if (got.re !== want.re) report_mismatch("out_real", got, want);
                if (got.im !== want.im) report_mismatch("out_imag", got, want);
                if (got.gain !== want.gain) report_mismatch("bin_gain", got, want);
            end
        end
    end

    // end of run and watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (stim_done) begin
            if (mismatches == 0 && expected_bins.size() == 0)
                $display("PASSED: all results match");
            else
                $display("FAILED: results differ");
            $finish;
        end else if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end
endmodule
